FILE: rtl/core/tcwc_pkg.sv
// Package: types, constants and helpers for the TCP congestion window control unit.
`default_nettype none
package tcwc_pkg;

	localparam int unsigned MSS_W = 16;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned PROD_W = 64;
	localparam logic [MSS_W-1:0] INITIAL_MSS_RESET = 16'd1460;
	localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [MSS_W-1:0] MSS_TWO_SEG = 16'd2190;
	localparam logic [MSS_W-1:0] MSS_THREE_SEG = 16'd1095;

	typedef enum logic [2:0] {
		REQ_NEW_ACK   = 3'd0,
		REQ_DUP_ACK   = 3'd1,
		REQ_TIMEOUT   = 3'd2,
		REQ_ENTER_SACK = 3'd3,
		REQ_SACK_ACK  = 3'd4,
		REQ_REDUCE_MSS = 3'd5,
		REQ_QUERY     = 3'd6,
		REQ_SPARE     = 3'd7
	} req_t;

	// datapath commands issued by the controller
	typedef struct packed {
		logic init;        // reinitialize state from mss
		logic load;        // capture input item
		logic start_div;   // launch divider
		logic div_sel;     // 0: mss*mss/cwnd, 1: rescale step (see phase)
		logic rescale_ph;  // 0: cwnd*new/old, 1: limit*new/old
		logic dlim_div;    // divider computes flight/mss
		logic commit;      // apply event update
		logic push;        // present result
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic [2:0] req;
		logic need_div;    // event needs a division
		logic reduce_ok;
		logic third_dup;
	} stat_t;

	function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W] ? ALL_ONES : s[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] sat_small(input logic [WORD_W-1:0] a,
			input logic [1:0] k);
		logic [WORD_W+1:0] p;
		p = {2'b00, a} * {{WORD_W{1'b0}}, k};
		return (p[WORD_W+1:WORD_W] != 2'b00) ? ALL_ONES : p[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] start_window(input logic [MSS_W-1:0] mss);
		logic [WORD_W-1:0] m;
		m = {{(WORD_W-MSS_W){1'b0}}, mss};
		if (mss > MSS_TWO_SEG) return m << 1;
		if (mss > MSS_THREE_SEG) return m + (m << 1);
		return m << 2;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tcwc_divider.sv
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module tcwc_divider (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [tcwc_pkg::PROD_W-1:0] dividend,
	input  wire logic [tcwc_pkg::WORD_W-1:0] divisor,
	output logic done,
	output logic [tcwc_pkg::PROD_W-1:0] quotient
);
	localparam int unsigned CNT_W = $clog2(tcwc_pkg::PROD_W + 1);

	logic [tcwc_pkg::WORD_W-1:0] rem_q;
	logic [tcwc_pkg::PROD_W-1:0] quo_q;
	logic [tcwc_pkg::WORD_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [tcwc_pkg::WORD_W:0] shifted;
	logic [tcwc_pkg::WORD_W:0] diff;
	logic ge;

	assign shifted = {rem_q, quo_q[tcwc_pkg::PROD_W-1]};
	assign diff = shifted - {1'b0, dvs_q};
	assign ge = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(tcwc_pkg::PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[tcwc_pkg::WORD_W-1:0] : shifted[tcwc_pkg::WORD_W-1:0];
			quo_q <= {quo_q[tcwc_pkg::PROD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

FILE: rtl/core/tcwc_datapath.sv
// Datapath: congestion state registers, event arithmetic and result register.
`default_nettype none
module tcwc_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tcwc_pkg::cmd_t cmd,
	output tcwc_pkg::stat_t stat,
	input  wire logic [tcwc_pkg::MSS_W-1:0] init_mss,
	input  wire logic [2:0] in_req,
	input  wire logic [tcwc_pkg::WORD_W-1:0] in_acked,
	input  wire logic [tcwc_pkg::WORD_W-1:0] in_flight,
	input  wire logic in_complete,
	input  wire logic [tcwc_pkg::MSS_W-1:0] in_new_mss,
	input  wire logic [tcwc_pkg::WORD_W-1:0] in_rwnd,
	output logic [98:0] result
);
	localparam int unsigned W = tcwc_pkg::WORD_W;
	localparam int unsigned MW = tcwc_pkg::MSS_W;

	logic [MW-1:0] mss_q;
	logic [W-1:0] cwnd_q, ssth_q, dup_q, lim_q;
	logic fr_q, sr_q;
	logic [2:0] req_q;
	logic [W-1:0] acked_q, flight_q, rwnd_q;
	logic cmpl_q;
	logic [MW-1:0] nmss_q;
	logic [W-1:0] scaled_q;
	logic [W-1:0] lim_div_q;
	logic [98:0] result_q;

	logic div_start, div_done;
	logic [tcwc_pkg::PROD_W-1:0] dividend, quotient;
	logic [W-1:0] divisor;
	logic [W-1:0] mss_w, nmss_w;
	logic [W-1:0] dup_next, half_thr, floor2;
	logic [W-1:0] inc;
	logic qsat;

	assign mss_w = {{(W-MW){1'b0}}, mss_q};
	assign nmss_w = {{(W-MW){1'b0}}, nmss_q};
	assign dup_next = tcwc_pkg::sat_add(dup_q, W'(1));
	assign floor2 = tcwc_pkg::sat_small(mss_w, 2'd2);
	assign half_thr = ((flight_q >> 1) > floor2) ? (flight_q >> 1) : floor2;

	always_comb begin
		dividend = '0;
		divisor = mss_w;
		if (cmd.dlim_div) begin
			dividend = {{W{1'b0}}, flight_q};
			divisor = mss_w;
		end else if (!cmd.div_sel) begin
			dividend = {{W{1'b0}}, mss_w * mss_w};
			divisor = cwnd_q;
		end else if (!cmd.rescale_ph) begin
			dividend = {{W{1'b0}}, cwnd_q} * {{(tcwc_pkg::PROD_W-MW){1'b0}}, nmss_q};
			divisor = mss_w;
		end else begin
			dividend = {{W{1'b0}}, lim_q} * {{(tcwc_pkg::PROD_W-MW){1'b0}}, nmss_q};
			divisor = mss_w;
		end
	end
	assign div_start = cmd.start_div;

	tcwc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dividend),
		.divisor(divisor), .done(div_done), .quotient(quotient)
	);

	assign qsat = quotient[tcwc_pkg::PROD_W-1:W] != '0;
	assign inc = (cwnd_q == '0) ? W'(1) :
		(qsat ? tcwc_pkg::ALL_ONES : ((quotient[W-1:0] > W'(1)) ? quotient[W-1:0] : W'(1)));

	assign stat.div_done = div_done;
	assign stat.req = req_q;
	assign stat.reduce_ok = (nmss_q != '0) && (nmss_q < mss_q);
	assign stat.third_dup = dup_next == W'(3);
	assign stat.need_div = ((req_q == tcwc_pkg::REQ_NEW_ACK) && !sr_q && !fr_q
		&& (acked_q != '0) && !(cwnd_q < ssth_q) && (cwnd_q != '0))
		|| ((req_q == tcwc_pkg::REQ_REDUCE_MSS) && stat.reduce_ok)
		|| ((req_q == tcwc_pkg::REQ_DUP_ACK) && stat.third_dup);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_req;
			acked_q <= in_acked;
			flight_q <= in_flight;
			cmpl_q <= in_complete;
			nmss_q <= in_new_mss;
			rwnd_q <= in_rwnd;
		end
		if (div_done && cmd.div_sel && !cmd.rescale_ph) scaled_q <= quotient[W-1:0];
		if (div_done && cmd.dlim_div) lim_div_q <= quotient[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [MW-1:0] m;
		if (!arst_n) begin
			mss_q <= tcwc_pkg::INITIAL_MSS_RESET;
			cwnd_q <= tcwc_pkg::start_window(tcwc_pkg::INITIAL_MSS_RESET);
			ssth_q <= tcwc_pkg::ALL_ONES;
			dup_q <= '0;
			lim_q <= '0;
			fr_q <= 1'b0;
			sr_q <= 1'b0;
		end else if (cmd.init) begin
			m = (init_mss == '0) ? MW'(1) : init_mss;
			mss_q <= m;
			cwnd_q <= tcwc_pkg::start_window(m);
			ssth_q <= tcwc_pkg::ALL_ONES;
			dup_q <= '0;
			lim_q <= '0;
			fr_q <= 1'b0;
			sr_q <= 1'b0;
		end else if (cmd.commit) begin
			case (req_q)
				tcwc_pkg::REQ_NEW_ACK: begin
					dup_q <= '0;
					lim_q <= '0;
					if (!sr_q) begin
						if (fr_q) begin
							cwnd_q <= ssth_q;
							fr_q <= 1'b0;
						end else if (acked_q != '0) begin
							if (cwnd_q < ssth_q)
								cwnd_q <= tcwc_pkg::sat_add(cwnd_q,
									(acked_q < mss_w) ? acked_q : mss_w);
							else
								cwnd_q <= tcwc_pkg::sat_add(cwnd_q, inc);
						end
					end
				end
				tcwc_pkg::REQ_DUP_ACK: begin
					dup_q <= dup_next;
					if (dup_next == W'(3)) begin
						ssth_q <= half_thr;
						cwnd_q <= tcwc_pkg::sat_add(half_thr,
							tcwc_pkg::sat_small(mss_w, 2'd3));
						lim_q <= lim_div_q;
						fr_q <= 1'b1;
					end else if (dup_next > W'(3) && fr_q && (dup_next - W'(3) < lim_q))
						cwnd_q <= tcwc_pkg::sat_add(cwnd_q, mss_w);
				end
				tcwc_pkg::REQ_TIMEOUT: begin
					ssth_q <= half_thr;
					cwnd_q <= mss_w;
					dup_q <= '0;
					lim_q <= '0;
					fr_q <= 1'b0;
					sr_q <= 1'b0;
				end
				tcwc_pkg::REQ_ENTER_SACK: begin
					ssth_q <= half_thr;
					cwnd_q <= half_thr;
					dup_q <= '0;
					lim_q <= '0;
					fr_q <= 1'b1;
					sr_q <= 1'b1;
				end
				tcwc_pkg::REQ_SACK_ACK: begin
					dup_q <= '0;
					lim_q <= '0;
					if (sr_q && cmpl_q) begin
						cwnd_q <= ssth_q;
						fr_q <= 1'b0;
						sr_q <= 1'b0;
					end
				end
				tcwc_pkg::REQ_REDUCE_MSS: begin
					if (stat.reduce_ok) begin
						cwnd_q <= (scaled_q > nmss_w) ? scaled_q : nmss_w;
						lim_q <= quotient[W-1:0];
						mss_q <= nmss_q;
					end
				end
				default: ;
			endcase
		end
	end

	logic [W-1:0] usable;
	logic retx_q;
	always_ff @(posedge clk) begin
		if (cmd.commit)
			retx_q <= (req_q == tcwc_pkg::REQ_DUP_ACK) && stat.third_dup;
	end
	assign usable = (cwnd_q < rwnd_q) ? cwnd_q : rwnd_q;

	// result: retx, allowance, cwnd, ssthresh, fr, sr (lowest first)
	always_ff @(posedge clk) begin
		if (cmd.push)
			result_q <= {sr_q, fr_q, ssth_q, cwnd_q,
				(flight_q >= usable) ? W'(0) : usable - flight_q, retx_q};
	end
	assign result = result_q;
endmodule
`default_nettype wire

FILE: rtl/core/tcwc_control.sv
// Controller: sequences load, division, commit and result hand-off per item.
`default_nettype none
module tcwc_control (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire tcwc_pkg::stat_t stat,
	output tcwc_pkg::cmd_t cmd
);
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_DIV1   = 7'b0000100,
		S_DIV2S  = 7'b0001000,
		S_DIV2   = 7'b0010000,
		S_COMMIT = 7'b0100000,
		S_PUSH   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic is_reduce, is_dup;

	assign is_reduce = stat.req == tcwc_pkg::REQ_REDUCE_MSS;
	assign is_dup = stat.req == tcwc_pkg::REQ_DUP_ACK;
	assign in_ready = (state_q == S_IDLE) && !cfg_we;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cmd.init = cfg_we;
		cmd.dlim_div = is_dup;
		cmd.div_sel = is_reduce;
		cmd.rescale_ph = (state_q == S_DIV2S) || (state_q == S_DIV2)
			|| (state_q == S_COMMIT);
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd.load = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: if (stat.need_div) begin
				cmd.start_div = 1'b1;
				state_d = S_DIV1;
			end else state_d = S_COMMIT;
			S_DIV1: if (stat.div_done) state_d = is_reduce ? S_DIV2S : S_COMMIT;
			S_DIV2S: begin
				cmd.start_div = 1'b1;
				state_d = S_DIV2;
			end
			S_DIV2: if (stat.div_done) state_d = S_COMMIT;
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: if (!out_valid_q || out_ready) begin
				cmd.push = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/tcp_congestion_window_control_unit.sv
// Top level: TCP congestion window control unit.
// channel | dir | tdata (low bit up)                         | tuser (low bit up)
// s_axis  | in  | acked_bytes, flight_bytes, new_mss, peer_win | req_type, recov_done
// m_axis  | out | send_budget, window_bytes, threshold_bytes  | resend_first, in_fr, in_sr
// cfg     | in  | initial_mss (cfg_we/cfg_data)
// One transfer at a time. An item without division runs from accept through the check,
// commit and push states back to idle. A congestion-avoidance ACK or third duplicate
// ACK adds one divider pass, an MSS reduction adds two passes, one after the other.
// The shared bit-serial divider serves both passes. Reset or a cfg write restores
// initial state. A waiting result holds in the output register; a new item is still taken,
// but its result is loaded only once the waiting one moves.
`default_nettype none
module tcp_congestion_window_control_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [15:0] cfg_data,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [111:0] s_axis_tdata,  // acked_bytes, flight_bytes, new_mss, peer_win
	input  wire logic [3:0] s_axis_tuser,    // req_type, recov_done
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [95:0] m_axis_tdata,        // send_budget, window_bytes, threshold_bytes
	output logic [2:0] m_axis_tuser          // resend_first, in_fr, in_sr
);
	tcwc_pkg::cmd_t cmd;
	tcwc_pkg::stat_t stat;
	logic [98:0] result;

	tcwc_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	tcwc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .init_mss(cfg_data),
		.in_req(s_axis_tuser[2:0]), .in_acked(s_axis_tdata[31:0]),
		.in_flight(s_axis_tdata[63:32]), .in_complete(s_axis_tuser[3]),
		.in_new_mss(s_axis_tdata[79:64]), .in_rwnd(s_axis_tdata[111:80]),
		.result(result)
	);

	assign m_axis_tdata = result[96:1];
	assign m_axis_tuser = {result[98], result[97], result[0]};
endmodule
`default_nettype wire
